FILE: hdl/cfmp_pkg.sv
// Shared types, constants and the CRC-8 step function of the CRC-8 framed message parser.
// No dependencies; compile this file first.
package cfmp_pkg;

	localparam int PAYLOAD_DEPTH = 512;
	localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

	typedef logic [7:0] byte_t;
	typedef logic [8:0] ridx_t;
	typedef logic [9:0] len10_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [9:0] cfg_data_t;

	localparam byte_t  HDR_FIRST_RST  = 8'd36;
	localparam byte_t  HDR_SECOND_RST = 8'd75;
	localparam len10_t MAX_LEN_RST    = 10'd512;
	localparam byte_t  POLY_RST       = 8'd7;

	typedef enum logic [1:0] {
		REG_HDR_FIRST  = 2'd0,
		REG_HDR_SECOND = 2'd1,
		REG_MAX_LEN    = 2'd2,
		REG_POLY       = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_ZERO_ID  = 2'd2,
		ERR_CRC      = 2'd3
	} err_t;

	typedef enum logic [6:0] {
		PH_SYNC0 = 7'b0000001,
		PH_SYNC1 = 7'b0000010,
		PH_LEN0  = 7'b0000100,
		PH_LEN1  = 7'b0001000,
		PH_IDENT = 7'b0010000,
		PH_CHECK = 7'b0100000,
		PH_DATA  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		byte_t data;
	} store_wr_t;

	// MSB-first CRC-8 over one byte, no reflection
	function automatic byte_t crc8_step(input byte_t crc, input byte_t b, input byte_t poly);
		byte_t v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ poly) : (v << 1);
		end
		return v;
	endfunction

endpackage

FILE: hdl/cfmp_in_if.sv
// Input channel of the framed message parser: valid/ready plus one link word.
// Depends on cfmp_pkg.
interface cfmp_in_if;
	import cfmp_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	byte_t data_byte;
	ridx_t read_index;

	modport source(output valid, action, data_byte, read_index, input ready);
	modport sink(input valid, action, data_byte, read_index, output ready);
endinterface

FILE: hdl/cfmp_out_if.sv
// Result channel of the framed message parser: valid/ready plus one result word.
// Depends on cfmp_pkg.
interface cfmp_out_if;
	import cfmp_pkg::*;

	logic   valid;
	logic   ready;
	byte_t  message_id;
	logic [1:0] error_code;
	len10_t frame_length;
	byte_t  read_data;

	modport source(output valid, message_id, error_code, frame_length, read_data, input ready);
	modport sink(input valid, message_id, error_code, frame_length, read_data, output ready);
endinterface

FILE: hdl/cfmp_payload_store.sv
// Payload byte store: one write port, one registered read port with write bypass.
// Depends on cfmp_pkg.
module cfmp_payload_store (
	input  logic              clk,
	input  cfmp_pkg::store_wr_t wr,
	input  logic              rd_en,
	input  cfmp_pkg::addr_t   rd_addr,
	output cfmp_pkg::byte_t   rd_data
);
	import cfmp_pkg::*;

	byte_t mem [PAYLOAD_DEPTH];
	byte_t rd_q;
	logic  hit_q;
	byte_t hit_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			hit_q      <= wr.en && (wr.addr == rd_addr);
			hit_data_q <= wr.data;
		end
	end

	assign rd_data = hit_q ? hit_data_q : rd_q;
endmodule

FILE: hdl/crc8_framed_message_parser_unit.sv
// Top level of the CRC-8 framed message parser: sync hunt, CRC, payload store, result register.
// Depends on cfmp_pkg, cfmp_in_if, cfmp_out_if and cfmp_payload_store.
//
//  channel  | dir | word
//  in_ch    | in  | action, data_byte, read_index
//  out_ch   | out | message_id, error_code, frame_length, read_data
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One word per cycle unless stalled; words pass an input register, then a result register.
// Payload reads go through the store's registered port, captured at accept.
// A polynomial write in mid-header recomputes the header CRC,
// with in_ch.ready low meanwhile.
// arst_n clears parser state and loads register defaults; the store is not cleared.
// out_ch.ready low holds the result; the input register still takes one more word.
module crc8_framed_message_parser_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfmp_pkg::cfg_idx_t    cfg_index,
	input  cfmp_pkg::cfg_data_t   cfg_wdata,
	cfmp_in_if.sink               in_ch,
	cfmp_out_if.source            out_ch
);
	import cfmp_pkg::*;

	// config
	byte_t  hdr1_q, hdr2_q, poly_q;
	len10_t maxlen_q;

	// frame state
	phase_t phase_q, phase_n;
	byte_t  len_lo_q, len_lo_n, len_hi_q, len_hi_n;
	byte_t  ident_q, ident_n, expect_q, expect_n, crc_q, crc_n;
	len10_t pos_q, pos_n, acc_len_q, acc_len_n;

	// header CRC recompute
	logic       busy_q;
	logic [1:0] k_q, hdr_cnt;
	byte_t      k_byte;

	// pipeline
	logic   valid_s1, action_s1, range_s1;
	byte_t  data_s1;
	logic   valid_s2;
	byte_t  id_s2, rdata_s2, id_n, store_rd;
	err_t   err_s2, err_n;
	len10_t flen_s2;

	logic      advance, accept, in_range;
	store_wr_t wr;
	len10_t    pos_inc;

	assign advance = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !busy_q && (!valid_s1 || advance);
	assign accept = in_ch.valid && in_ch.ready;
	assign in_range = ({23'd0, in_ch.read_index} < 32'(PAYLOAD_DEPTH));
	assign pos_inc = pos_q + 10'd1;

	cfmp_payload_store u_store (
		.clk    (clk),
		.wr     (wr),
		.rd_en  (accept),
		.rd_addr(ADDR_W'(in_ch.read_index)),
		.rd_data(store_rd)
	);

	always_comb begin
		phase_n   = phase_q;
		len_lo_n  = len_lo_q;
		len_hi_n  = len_hi_q;
		ident_n   = ident_q;
		expect_n  = expect_q;
		crc_n     = crc_q;
		pos_n     = pos_q;
		acc_len_n = acc_len_q;
		id_n      = 8'd0;
		err_n     = ERR_NONE;
		wr.en     = 1'b0;
		wr.addr   = ADDR_W'(pos_q);
		wr.data   = data_s1;
		if (!action_s1) begin
			case (phase_q)
				PH_SYNC1: begin
					phase_n = (data_s1 == hdr2_q) ? PH_LEN0 : PH_SYNC0;
				end
				PH_LEN0: begin
					len_lo_n = data_s1;
					crc_n    = crc8_step(8'd0, data_s1, poly_q);
					phase_n  = PH_LEN1;
				end
				PH_LEN1: begin
					if ({data_s1, len_lo_q} > {6'd0, maxlen_q}) begin
						err_n    = ERR_TOO_LONG;
						phase_n  = PH_SYNC0;
						len_lo_n = 8'd0;
						len_hi_n = 8'd0;
						ident_n  = 8'd0;
						expect_n = 8'd0;
						crc_n    = 8'd0;
						pos_n    = 10'd0;
					end else begin
						len_hi_n = data_s1;
						crc_n    = crc8_step(crc_q, data_s1, poly_q);
						phase_n  = PH_IDENT;
					end
				end
				PH_IDENT: begin
					if (data_s1 == 8'd0) begin
						err_n    = ERR_ZERO_ID;
						phase_n  = PH_SYNC0;
						len_lo_n = 8'd0;
						len_hi_n = 8'd0;
						ident_n  = 8'd0;
						expect_n = 8'd0;
						crc_n    = 8'd0;
						pos_n    = 10'd0;
					end else begin
						ident_n = data_s1;
						crc_n   = crc8_step(crc_q, data_s1, poly_q);
						phase_n = PH_CHECK;
					end
				end
				PH_CHECK: begin
					expect_n = data_s1;
					pos_n    = 10'd0;
					if ({len_hi_q, len_lo_q} == 16'd0) begin
						phase_n = PH_SYNC0;
						if (crc_q != data_s1) begin
							err_n    = ERR_CRC;
							len_lo_n = 8'd0;
							len_hi_n = 8'd0;
							ident_n  = 8'd0;
							expect_n = 8'd0;
							crc_n    = 8'd0;
						end else begin
							id_n      = ident_q;
							acc_len_n = 10'd0;
						end
					end else begin
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					wr.en = ({22'd0, pos_q} < 32'(PAYLOAD_DEPTH));
					crc_n = crc8_step(crc_q, data_s1, poly_q);
					pos_n = pos_inc;
					if ({6'd0, pos_inc} == {len_hi_q, len_lo_q}) begin
						phase_n = PH_SYNC0;
						if (crc_n != expect_q) begin
							err_n    = ERR_CRC;
							len_lo_n = 8'd0;
							len_hi_n = 8'd0;
							ident_n  = 8'd0;
							expect_n = 8'd0;
							crc_n    = 8'd0;
							pos_n    = 10'd0;
						end else begin
							id_n      = ident_q;
							acc_len_n = {len_hi_q[1:0], len_lo_q};
						end
					end
				end
				default: begin
					phase_n = PH_SYNC0;
					if (data_s1 == hdr1_q) begin
						phase_n  = PH_SYNC1;
						len_lo_n = 8'd0;
						len_hi_n = 8'd0;
						ident_n  = 8'd0;
						expect_n = 8'd0;
						crc_n    = 8'd0;
						pos_n    = 10'd0;
					end
				end
			endcase
		end
		wr.en = wr.en && advance;
	end

	// header bytes already folded into crc_q, per phase
	always_comb begin
		case (phase_q)
			PH_LEN1:  hdr_cnt = 2'd1;
			PH_IDENT: hdr_cnt = 2'd2;
			PH_CHECK: hdr_cnt = 2'd3;
			default:  hdr_cnt = 2'd0;
		endcase
		case (k_q)
			2'd0:    k_byte = len_lo_q;
			2'd1:    k_byte = len_hi_q;
			default: k_byte = ident_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q    <= HDR_FIRST_RST;
			hdr2_q    <= HDR_SECOND_RST;
			maxlen_q  <= MAX_LEN_RST;
			poly_q    <= POLY_RST;
			phase_q   <= PH_SYNC0;
			len_lo_q  <= 8'd0;
			len_hi_q  <= 8'd0;
			ident_q   <= 8'd0;
			expect_q  <= 8'd0;
			crc_q     <= 8'd0;
			pos_q     <= 10'd0;
			acc_len_q <= 10'd0;
			busy_q    <= 1'b0;
			k_q       <= 2'd0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HDR_FIRST:  hdr1_q   <= cfg_wdata[7:0];
					REG_HDR_SECOND: hdr2_q   <= cfg_wdata[7:0];
					REG_MAX_LEN:    maxlen_q <= cfg_wdata;
					REG_POLY:       poly_q   <= cfg_wdata[7:0];
					default:        hdr1_q   <= hdr1_q;
				endcase
			end
			if (cfg_we && cfg_index == REG_POLY) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (busy_q) begin
				if (k_q < hdr_cnt) begin
					crc_q <= crc8_step((k_q == 2'd0) ? 8'd0 : crc_q, k_byte, poly_q);
					k_q   <= k_q + 2'd1;
				end else begin
					busy_q <= 1'b0;
				end
			end else if (advance) begin
				phase_q   <= phase_n;
				len_lo_q  <= len_lo_n;
				len_hi_q  <= len_hi_n;
				ident_q   <= ident_n;
				expect_q  <= expect_n;
				crc_q     <= crc_n;
				pos_q     <= pos_n;
				acc_len_q <= acc_len_n;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= in_ch.action;
			data_s1   <= in_ch.data_byte;
			range_s1  <= in_range;
		end
		if (advance) begin
			id_s2    <= id_n;
			err_s2   <= err_n;
			flen_s2  <= acc_len_n;
			rdata_s2 <= (action_s1 && range_s1) ? store_rd : 8'd0;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.message_id   = id_s2;
	assign out_ch.error_code   = err_s2;
	assign out_ch.frame_length = flen_s2;
	assign out_ch.read_data    = rdata_s2;
endmodule

FILE: sim/testbench.sv
// Self-checking bench for crc8_framed_message_parser_unit: directed words, then framed traffic.
// Predicts untyped result words with its parser model and scores all against the DUT output.
// Depends on cfmp_pkg, cfmp_in_if, cfmp_out_if and crc8_framed_message_parser_unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cfmp_pkg::*;

	typedef struct packed {
		byte_t      id;
		logic [1:0] err;
		len10_t     len;
		byte_t      rd;
	} result_t;

	typedef struct packed {
		logic    act;
		byte_t   data;
		ridx_t   ridx;
		logic    typed;
		result_t want;
	} stim_row_t;

	typedef enum {
		SEQ_GOOD, SEQ_BAD_CRC, SEQ_TOO_LONG, SEQ_ZERO_ID, SEQ_CUT, SEQ_WRONG_SYNC, SEQ_NOISE
	} seq_t;

	localparam int N_OPEN = 26;
	localparam int PHASE_WORDS = 60;
	localparam int LONG_HOLD = 300;

	// typed rows carry their result; the rest go through the predictor
	localparam stim_row_t OPENING_WORDS [N_OPEN] = '{
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd36, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h11, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd36, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd75, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'hFF, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'hFF, 9'd0, 1'b1, '{8'd0, ERR_TOO_LONG, 10'd0, 8'd0}},
		'{1'b0, 8'd36, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd75, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_ZERO_ID, 10'd0, 8'd0}},
		'{1'b0, 8'd36, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd75, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'hFF, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'hF3, 9'd0, 1'b0, '0},
		'{1'b0, 8'd36, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'd75, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h01, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h80, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'h00, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'd0}},
		'{1'b0, 8'hA5, 9'd0, 1'b0, '0},
		'{1'b1, 8'hFF, 9'd0, 1'b1, '{8'd0, ERR_NONE, 10'd0, 8'hA5}}
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_wdata;

	cfmp_in_if  in_ch();
	cfmp_out_if out_ch();

	crc8_framed_message_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// register shadow
	byte_t  hdr_a, hdr_b, poly;
	len10_t len_cap;

	// parser shadow
	phase_t      ph;
	logic [15:0] frame_len;
	byte_t       frame_id, sent_check, calc_check;
	logic [9:0]  pos;
	len10_t      last_len;
	byte_t       payload_mem [PAYLOAD_DEPTH];
	int          mem_top;

	result_t pending_results [$];
	int      fail_count;
	int      word_count;
	bit      idle_on;
	bit      hold_req;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("testbench failed");
		$finish;
	end

	function automatic byte_t crc8_next(byte_t crc, byte_t b);
		byte_t r;
		r = crc ^ b;
		for (int i = 0; i < 8; i++)
			r = {r[6:0], 1'b0} ^ (r[7] ? poly : 8'h00);
		return r;
	endfunction

	function automatic void drop_frame();
		ph = PH_SYNC0;
		frame_len = '0;
		frame_id = '0;
		sent_check = '0;
		calc_check = '0;
		pos = '0;
	endfunction

	function automatic void close_frame(inout result_t r);
		if (calc_check != sent_check) begin
			r.err = ERR_CRC;
			drop_frame();
		end else begin
			r.id = frame_id;
			last_len = frame_len[9:0];
			ph = PH_SYNC0;
		end
	endfunction

	function automatic result_t parse_word(logic act, byte_t c, ridx_t ridx);
		result_t r;
		r = '0;
		if (act) begin
			r.rd = payload_mem[ridx];
		end else begin
			case (ph)
				PH_SYNC1: ph = (c == hdr_b) ? PH_LEN0 : PH_SYNC0;
				PH_LEN0: begin
					frame_len = {8'h00, c};
					ph = PH_LEN1;
				end
				PH_LEN1: begin
					frame_len = {c, frame_len[7:0]};
					if (frame_len > {6'd0, len_cap}) begin
						r.err = ERR_TOO_LONG;
						drop_frame();
					end else begin
						ph = PH_IDENT;
					end
				end
				PH_IDENT: begin
					if (c == 8'h00) begin
						r.err = ERR_ZERO_ID;
						drop_frame();
					end else begin
						frame_id = c;
						ph = PH_CHECK;
					end
				end
				PH_CHECK: begin
					sent_check = c;
					pos = '0;
					calc_check = crc8_next(crc8_next(crc8_next(8'h00, frame_len[7:0]),
						frame_len[15:8]), frame_id);
					if (frame_len == 16'd0)
						close_frame(r);
					else
						ph = PH_DATA;
				end
				PH_DATA: begin
					if (pos < PAYLOAD_DEPTH) begin
						payload_mem[pos[8:0]] = c;
						if (mem_top < int'(pos) + 1)
							mem_top = int'(pos) + 1;
					end
					calc_check = crc8_next(calc_check, c);
					pos = pos + 10'd1;
					if ({6'd0, pos} == frame_len)
						close_frame(r);
				end
				default: begin
					if (c == hdr_a) begin
						drop_frame();
						ph = PH_SYNC1;
					end else begin
						ph = PH_SYNC0;
					end
				end
			endcase
		end
		r.len = last_len;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic offer_word(logic act, byte_t c, ridx_t ridx, logic typed, result_t want);
		int gap;
		result_t pred;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.action     <= act;
		in_ch.data_byte  <= c;
		in_ch.read_index <= ridx;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (act || ph != PH_SYNC0 || c == hdr_a)
			word_count++;
		pred = parse_word(act, c, ridx);
		pending_results.push_back(typed ? want : pred);
	endtask

	// link byte, sometimes preceded by a read of the store
	task automatic send_link_byte(byte_t c);
		if (mem_top > 0 && $urandom_range(0, 7) == 0)
			offer_word(1'b1, byte_t'($urandom), ridx_t'($urandom_range(0, mem_top - 1)),
				1'b0, '0);
		offer_word(1'b0, c, ridx_t'($urandom), 1'b0, '0);
	endtask

	task automatic send_frame(seq_t kind, int fixed_len);
		logic [15:0] len;
		byte_t id, chk;
		byte_t words [$];
		int pick, n;
		pick = $urandom_range(0, 39);
		if (kind == SEQ_TOO_LONG)
			len = ($urandom_range(0, 1) == 0) ? 16'(len_cap) + 16'd1
				: 16'($urandom_range(int'(len_cap) + 1, 65535));
		else if (fixed_len >= 0)
			len = 16'(fixed_len);
		else if (pick == 0)
			len = 16'(len_cap);
		else if (pick == 1)
			len = 16'($urandom_range(0, len_cap));
		else
			len = 16'($urandom_range(0, (len_cap < 12) ? int'(len_cap) : 12));
		id = (kind == SEQ_ZERO_ID) ? 8'h00 : byte_t'($urandom_range(1, 255));
		chk = crc8_next(crc8_next(crc8_next(8'h00, len[7:0]), len[15:8]), id);
		words = '{hdr_a, hdr_b, len[7:0], len[15:8], id, 8'h00};
		if (kind != SEQ_TOO_LONG) begin
			for (int i = 0; i < int'(len); i++) begin
				words.push_back(byte_t'($urandom));
				chk = crc8_next(chk, words[6 + i]);
			end
		end
		if (kind == SEQ_BAD_CRC)
			chk ^= byte_t'($urandom_range(1, 255));
		words[5] = chk;
		case (kind)
			SEQ_TOO_LONG: n = 4;
			SEQ_ZERO_ID:  n = 5;
			SEQ_CUT:      n = $urandom_range(1, words.size() - 1);
			default:      n = words.size();
		endcase
		for (int i = 0; i < n; i++)
			send_link_byte(words[i]);
	endtask

	task automatic load_config(byte_t h1, byte_t h2, len10_t ml, byte_t pl);
		cfg_data_t vals [4];
		cfg_reg_t r;
		vals = '{cfg_data_t'(h1), cfg_data_t'(h2), ml, cfg_data_t'(pl)};
		r = r.first();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= vals[i];
			@(posedge clk);
			r = r.next();
		end
		cfg_we <= 1'b0;
		hdr_a = h1;
		hdr_b = h2;
		len_cap = ml;
		poly = pl;
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side
	initial begin : result_sink
		int stall;
		result_t want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = idle_on ? $urandom_range(0, 11) : 0;
			end
			repeat (stall) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$error("result word with no expectation pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("message_id", want.id, out_ch.message_id);
				check_field("error_code", want.err, out_ch.error_code);
				check_field("frame_length", want.len, out_ch.frame_length);
				check_field("read_data", want.rd, out_ch.read_data);
			end
		end
	end

	initial begin : stimulus
		int roll;
		seq_t kind;
		byte_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.action = 1'b0;
		in_ch.data_byte = '0;
		in_ch.read_index = '0;
		fail_count = 0;
		word_count = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		mem_top = 0;
		hdr_a = HDR_FIRST_RST;
		hdr_b = HDR_SECOND_RST;
		len_cap = MAX_LEN_RST;
		poly = POLY_RST;
		last_len = '0;
		drop_frame();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_OPEN; i++)
			offer_word(OPENING_WORDS[i].act, OPENING_WORDS[i].data, OPENING_WORDS[i].ridx,
				OPENING_WORDS[i].typed, OPENING_WORDS[i].want);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: load_config(8'h00, 8'hFF, 10'd512, 8'h31);
				1: load_config(8'hFF, 8'h00, 10'd0, 8'hFF);
				2: load_config(byte_t'($urandom), byte_t'($urandom),
					len10_t'($urandom_range(0, 512)), 8'h00);
				3: load_config(8'hAA, 8'hAA, 10'd511, 8'h1D);
				4: load_config(byte_t'($urandom), byte_t'($urandom),
					len10_t'($urandom_range(0, 512)), byte_t'($urandom));
				default: load_config(HDR_FIRST_RST, HDR_SECOND_RST, MAX_LEN_RST, POLY_RST);
			endcase
			idle_on = (p != 2);
			hold_req = (p == 0);
			if (len_cap == len10_t'(PAYLOAD_DEPTH) && p == 5)
				send_frame(SEQ_GOOD, PAYLOAD_DEPTH);
			word_count = 0;
			while (word_count < PHASE_WORDS) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)      kind = SEQ_GOOD;
				else if (roll < 70) kind = SEQ_BAD_CRC;
				else if (roll < 77) kind = SEQ_TOO_LONG;
				else if (roll < 82) kind = SEQ_ZERO_ID;
				else if (roll < 88) kind = SEQ_CUT;
				else if (roll < 93) kind = SEQ_WRONG_SYNC;
				else                kind = SEQ_NOISE;
				case (kind)
					SEQ_WRONG_SYNC: begin
						send_link_byte(hdr_a);
						send_link_byte(hdr_b ^ byte_t'($urandom_range(1, 255)));
					end
					SEQ_NOISE: repeat ($urandom_range(1, 6)) send_link_byte(byte_t'($urandom));
					default: send_frame(kind, -1);
				endcase
			end
			// walk the parser back to sync hunt before the next register load
			while (ph != PH_SYNC0) begin
				case (ph)
					PH_SYNC1: c = ~hdr_b;
					PH_LEN0, PH_LEN1: c = 8'hFF;
					default: c = 8'h00;
				endcase
				offer_word(1'b0, c, ridx_t'($urandom), 1'b0, '0);
			end
			settle();
		end

		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/cfmp_pkg.sv
hdl/cfmp_in_if.sv
hdl/cfmp_out_if.sv
hdl/cfmp_payload_store.sv
hdl/crc8_framed_message_parser_unit.sv
sim/testbench.sv
